>>> design/hte_pkg.sv
`default_nettype none

package hte_pkg;

  // Document modes.
  typedef enum logic [2:0] {
    MODE_TAG     = 3'd0,
    MODE_TEXT    = 3'd1,
    MODE_SCRIPT  = 3'd2,
    MODE_STYLE   = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_t;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [3:0] SCRIPT_CLOSE_LEN = 4'd9;
  localparam logic [3:0] STYLE_CLOSE_LEN  = 4'd8;
  localparam logic [2:0] SCRIPT_NAME_LEN  = 3'd6;
  localparam logic [2:0] STYLE_NAME_LEN   = 3'd5;

  localparam logic [1:0] OPENER_LT   = 2'd1;
  localparam logic [1:0] OPENER_BANG = 2'd2;
  localparam logic [1:0] OPENER_DASH = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       doc_end;
  } out_item_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] opener_progress;
    logic [2:0] name_progress;
    logic       not_script;
    logic       not_style;
    logic       name_ended;
    logic [3:0] close_progress;
    logic [1:0] dash_run;
    logic       prev_was_space;
    logic       any_emitted;
  } hte_state_t;

  localparam hte_state_t STATE_RST = '{
    mode:            MODE_TAG,
    opener_progress: 2'd0,
    name_progress:   3'd0,
    not_script:      1'b0,
    not_style:       1'b0,
    name_ended:      1'b0,
    close_progress:  4'd0,
    dash_run:        2'd0,
    prev_was_space:  1'b1,
    any_emitted:     1'b0
  };

  // "</script>"
  function automatic logic [7:0] script_close_at(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h3C;
      4'd1:    ch = 8'h2F;
      4'd2:    ch = 8'h73;
      4'd3:    ch = 8'h63;
      4'd4:    ch = 8'h72;
      4'd5:    ch = 8'h69;
      4'd6:    ch = 8'h70;
      4'd7:    ch = 8'h74;
      4'd8:    ch = 8'h3E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "</style>"
  function automatic logic [7:0] style_close_at(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h3C;
      4'd1:    ch = 8'h2F;
      4'd2:    ch = 8'h73;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h79;
      4'd5:    ch = 8'h6C;
      4'd6:    ch = 8'h65;
      4'd7:    ch = 8'h3E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "script"
  function automatic logic [7:0] script_name_at(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h73;
      3'd1:    ch = 8'h63;
      3'd2:    ch = 8'h72;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h70;
      3'd5:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "style"
  function automatic logic [7:0] style_name_at(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h73;
      3'd1:    ch = 8'h74;
      3'd2:    ch = 8'h79;
      3'd3:    ch = 8'h6C;
      3'd4:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> design/hte_step.sv
`default_nettype none

// Next-state and result logic for one document byte.
module hte_step (
  input  wire  hte_pkg::hte_state_t st,
  input  wire  hte_pkg::in_item_t   item,
  output hte_pkg::hte_state_t       st_nxt,
  output hte_pkg::out_item_t        res
);
  import hte_pkg::*;

  logic [7:0] c;
  logic [7:0] c_text;
  logic [7:0] lc;
  logic       is_ws;
  logic [3:0] cp;
  logic [3:0] cp_nxt;
  logic [3:0] close_len;
  logic [7:0] close_ch;
  logic       close_hit;

  assign c      = item.data_byte;
  assign is_ws  = (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  assign lc     = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  assign c_text = ((c == CH_LF) || (c == CH_TAB)) ? CH_SPACE : c;

  // Closing-tag matcher, shared by script and style bodies.
  assign close_len = (st.mode == MODE_SCRIPT) ? SCRIPT_CLOSE_LEN : STYLE_CLOSE_LEN;
  assign cp        = (st.close_progress >= close_len) ? 4'd0 : st.close_progress;
  assign close_ch  = (st.mode == MODE_SCRIPT) ? script_close_at(cp) : style_close_at(cp);
  assign cp_nxt    = (c == close_ch) ? (cp + 4'd1) : ((c == CH_LT) ? 4'd1 : 4'd0);
  assign close_hit = (cp_nxt == close_len);

  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (st.mode)
      MODE_TEXT: begin
        if (c == CH_LT) begin
          st_nxt.mode            = MODE_TAG;
          st_nxt.opener_progress = 2'd0;
          st_nxt.close_progress  = 4'd0;
          st_nxt.dash_run        = 2'd0;
          st_nxt.name_progress   = 3'd0;
          st_nxt.not_script      = 1'b0;
          st_nxt.not_style       = 1'b0;
          st_nxt.name_ended      = 1'b0;
        end else if (!((c_text == CH_SPACE) && st.prev_was_space)) begin
          res.text_byte         = c_text;
          res.text_valid        = 1'b1;
          st_nxt.prev_was_space = (c_text == CH_SPACE);
          st_nxt.any_emitted    = 1'b1;
        end
      end
      MODE_SCRIPT, MODE_STYLE: begin
        if (close_hit) begin
          st_nxt.mode            = MODE_TAG;
          st_nxt.opener_progress = 2'd0;
          st_nxt.close_progress  = 4'd0;
          st_nxt.dash_run        = 2'd0;
          st_nxt.name_progress   = 3'd0;
          st_nxt.not_script      = 1'b0;
          st_nxt.not_style       = 1'b0;
          st_nxt.name_ended      = 1'b0;
        end else begin
          st_nxt.close_progress = cp_nxt;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_DASH) begin
          if (st.dash_run < 2'd2) begin
            st_nxt.dash_run = st.dash_run + 2'd1;
          end
        end else if ((c == CH_GT) && (st.dash_run >= 2'd2)) begin
          st_nxt.mode            = MODE_TAG;
          st_nxt.opener_progress = 2'd0;
          st_nxt.close_progress  = 4'd0;
          st_nxt.dash_run        = 2'd0;
          st_nxt.name_progress   = 3'd0;
          st_nxt.not_script      = 1'b0;
          st_nxt.not_style       = 1'b0;
          st_nxt.name_ended      = 1'b0;
        end else begin
          st_nxt.dash_run = 2'd0;
        end
      end
      default: begin
        st_nxt.mode = MODE_TAG;
        if (c == CH_LT) begin
          st_nxt.name_progress   = 3'd0;
          st_nxt.not_script      = 1'b0;
          st_nxt.not_style       = 1'b0;
          st_nxt.name_ended      = 1'b0;
          st_nxt.opener_progress = OPENER_LT;
        end else if (c == CH_GT) begin
          st_nxt.opener_progress = 2'd0;
          if (!st.not_script && (st.name_progress == SCRIPT_NAME_LEN)) begin
            st_nxt.mode           = MODE_SCRIPT;
            st_nxt.close_progress = 4'd0;
          end else if (!st.not_style && (st.name_progress == STYLE_NAME_LEN)) begin
            st_nxt.mode           = MODE_STYLE;
            st_nxt.close_progress = 4'd0;
          end else begin
            st_nxt.mode = MODE_TEXT;
            if (st.any_emitted && !st.prev_was_space) begin
              res.text_byte         = CH_SPACE;
              res.text_valid        = 1'b1;
              st_nxt.prev_was_space = 1'b1;
            end
          end
          st_nxt.name_progress = 3'd0;
          st_nxt.not_script    = 1'b0;
          st_nxt.not_style     = 1'b0;
          st_nxt.name_ended    = 1'b0;
        end else if ((st.opener_progress == OPENER_DASH) && (c == CH_DASH)) begin
          st_nxt.opener_progress = 2'd0;
          st_nxt.mode            = MODE_COMMENT;
          st_nxt.dash_run        = 2'd0;
          st_nxt.name_progress   = 3'd0;
          st_nxt.not_script      = 1'b0;
          st_nxt.not_style       = 1'b0;
          st_nxt.name_ended      = 1'b0;
        end else begin
          if ((st.opener_progress == OPENER_LT) && (c == CH_BANG)) begin
            st_nxt.opener_progress = OPENER_BANG;
          end else if ((st.opener_progress == OPENER_BANG) && (c == CH_DASH)) begin
            st_nxt.opener_progress = OPENER_DASH;
          end else begin
            st_nxt.opener_progress = 2'd0;
          end
          // Tag name: lower-cased, cut at the first whitespace.
          if (!st.name_ended) begin
            if (is_ws) begin
              st_nxt.name_ended = 1'b1;
            end else begin
              if (!((st.name_progress < SCRIPT_NAME_LEN) &&
                    (lc == script_name_at(st.name_progress)))) begin
                st_nxt.not_script = 1'b1;
              end
              if (!((st.name_progress < STYLE_NAME_LEN) &&
                    (lc == style_name_at(st.name_progress)))) begin
                st_nxt.not_style = 1'b1;
              end
              if (st.name_progress < 3'd7) begin
                st_nxt.name_progress = st.name_progress + 3'd1;
              end
            end
          end
        end
      end
    endcase
    res.doc_end = item.last_byte;
    // Every document starts from a clean machine.
    if (item.last_byte) begin
      st_nxt = STATE_RST;
    end
  end

endmodule

`default_nettype wire

>>> design/html_text_extractor_top.sv
`default_nettype none

// The result item for a byte is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while out_ready holds; the parser state and the result register update
// together in that cycle, so the rate is set by the single state register loop.
// Reset: rst_n is synchronous and active low; it empties the result register and
// returns the parser to tag mode with no text emitted.
module html_text_extractor_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  hte_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output hte_pkg::out_item_t  out_item
);
  import hte_pkg::*;

  // Parser state, updated once for every accepted item.
  hte_state_t state_r;
  hte_state_t state_nxt;

  // Result register. Every byte produces exactly one result item, so the
  // register holds one item at most.
  out_item_t  res_r;
  out_item_t  res_nxt;
  logic       res_valid_r;

  logic       in_fire;
  logic       out_fire;

  // A new item may enter whenever the result register is empty or is being
  // drained in this same cycle.
  assign in_ready  = !res_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = res_valid_r && out_ready;
  assign out_valid = res_valid_r;
  assign out_item  = res_r;

  // All per-byte decisions: mode changes, tag-name matching, closing-tag
  // matching, comment tracking and whitespace folding.
  hte_step u_step (
    .st     (state_r),
    .item   (in_item),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RST;
      res_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        res_valid_r <= 1'b1;
      end else if (out_fire) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // The payload needs no reset; it is qualified by res_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  // The final byte of a document leaves the parser in its reset state.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.last_byte |=> state_r == STATE_RST)
    else $error("parser state not cleared after last byte");

  // Bodies of script, style and comment blocks never produce text.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (state_r.mode == MODE_SCRIPT || state_r.mode == MODE_STYLE ||
                state_r.mode == MODE_COMMENT) |=> !res_r.text_valid)
    else $error("text emitted from a dropped body");

  // After a space is emitted the next space must be folded away.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_nxt.text_valid && res_nxt.text_byte == CH_SPACE |=>
      state_r.prev_was_space)
    else $error("space emitted without marking prev_was_space");

  // No text means a zero byte in the result.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.text_valid |-> res_r.text_byte == 8'h00)
    else $error("text_byte set without text_valid");

  // The end-of-document flag follows the accepted item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> res_r.doc_end == $past(in_item.last_byte))
    else $error("doc_end does not follow last_byte");

endmodule

`default_nettype wire
